// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker (bfla_chk).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define BFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define BFLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bfla_pkg.sv =====
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared types and codes for the buffer free-list allocator.
// ----------------------------------------------------------------------------
package bfla_pkg;

  localparam int BUFFERS_DEF = 256;

  // Operation codes on in_func
  localparam logic [1:0] FUNC_GET       = 2'd0;
  localparam logic [1:0] FUNC_FREE_TAIL = 2'd1;
  localparam logic [1:0] FUNC_FREE_HEAD = 2'd2;
  localparam logic [1:0] FUNC_SET_PIN   = 2'd3;

  // Result status codes on out_status
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_LISTED    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GET_CHK,
    ST_GET_EVAL,
    ST_FREE_CHK,
    ST_FREE_EVAL,
    ST_PIN_WR
  } state_t;

  typedef enum logic [1:0] {
    RES_GRANT,
    RES_EXHAUST,
    RES_ECHO_DONE,
    RES_ECHO_LISTED
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic rd_en;
    logic rd_head;
    logic pop;
    logic free_upd;
    logic pin_wr;
    logic emit;
    res_t res;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic empty;
    logic in_range;
    logic listed;
    logic pinned;
    logic last_pop;
  } stat_t;

endpackage

// ===== rtl/bfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfla_ctrl
// Sequencer for the allocator: clearing pass, get, free and pin flows.
// ----------------------------------------------------------------------------
module bfla_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_func,
  input  bfla_pkg::stat_t    stat,
  output bfla_pkg::cmd_t     cmd,
  output logic               busy
);

  bfla_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfla_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfla_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = bfla_pkg::ST_IDLE;
      end
      bfla_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_func)
            bfla_pkg::FUNC_GET:       state_nxt = bfla_pkg::ST_GET_CHK;
            bfla_pkg::FUNC_FREE_TAIL: state_nxt = bfla_pkg::ST_FREE_CHK;
            bfla_pkg::FUNC_FREE_HEAD: state_nxt = bfla_pkg::ST_FREE_CHK;
            bfla_pkg::FUNC_SET_PIN:   state_nxt = bfla_pkg::ST_PIN_WR;
            default:                  state_nxt = bfla_pkg::ST_IDLE;
          endcase
        end
      end
      bfla_pkg::ST_GET_CHK: begin
        state_nxt = stat.empty ? bfla_pkg::ST_IDLE : bfla_pkg::ST_GET_EVAL;
      end
      bfla_pkg::ST_GET_EVAL: begin
        // skip a pinned entry and try the next one
        if (stat.pinned && !stat.last_pop) state_nxt = bfla_pkg::ST_GET_CHK;
        else state_nxt = bfla_pkg::ST_IDLE;
      end
      bfla_pkg::ST_FREE_CHK: begin
        state_nxt = stat.in_range ? bfla_pkg::ST_FREE_EVAL : bfla_pkg::ST_IDLE;
      end
      bfla_pkg::ST_FREE_EVAL: state_nxt = bfla_pkg::ST_IDLE;
      bfla_pkg::ST_PIN_WR:    state_nxt = bfla_pkg::ST_IDLE;
      default:                state_nxt = bfla_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res      = bfla_pkg::RES_ECHO_DONE;
    busy         = 1'b1;
    unique case (state_r)
      bfla_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      bfla_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      bfla_pkg::ST_GET_CHK: begin
        if (stat.empty) begin
          cmd.emit = 1'b1;
          cmd.res  = bfla_pkg::RES_EXHAUST;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_head = 1'b1;
        end
      end
      bfla_pkg::ST_GET_EVAL: begin
        cmd.pop = 1'b1;
        if (!stat.pinned) begin
          cmd.emit = 1'b1;
          cmd.res  = bfla_pkg::RES_GRANT;
        end else if (stat.last_pop) begin
          cmd.emit = 1'b1;
          cmd.res  = bfla_pkg::RES_EXHAUST;
        end
      end
      bfla_pkg::ST_FREE_CHK: begin
        if (stat.in_range) begin
          cmd.rd_en = 1'b1;
        end else begin
          cmd.emit = 1'b1;
        end
      end
      bfla_pkg::ST_FREE_EVAL: begin
        cmd.emit = 1'b1;
        if (stat.listed) begin
          cmd.res = bfla_pkg::RES_ECHO_LISTED;
        end else begin
          cmd.free_upd = 1'b1;
        end
      end
      bfla_pkg::ST_PIN_WR: begin
        cmd.pin_wr = stat.in_range;
        cmd.emit   = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/bfla_dp.sv =====
// ----------------------------------------------------------------------------
// bfla_dp
// Link, listed and pinned memories, head/tail pointers and result register.
// ----------------------------------------------------------------------------
module bfla_dp #(
  parameter int BUFFERS = bfla_pkg::BUFFERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bfla_pkg::cmd_t     cmd,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_buffer_index,
  input  logic               in_pin_flag,
  output bfla_pkg::stat_t    stat,
  output logic               out_valid,
  output logic [7:0]         out_granted_index,
  output logic [1:0]         out_status
);

  localparam int IDX_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFERS - 1);

  logic [IDX_W-1:0] link_mem   [BUFFERS];
  logic             listed_mem [BUFFERS];
  logic             pinned_mem [BUFFERS];

  logic [IDX_W-1:0] head_r, tail_r, clr_cnt_r;
  logic             empty_r;
  logic [1:0]       func_r;
  logic [7:0]       idx8_r;
  logic             pin_r;
  logic [IDX_W-1:0] link_rd_r;
  logic             listed_rd_r, pinned_rd_r;
  logic             out_valid_r;
  logic [7:0]       granted_r;
  logic [1:0]       status_r;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] clr_next;
  logic             link_we, listed_we, pinned_we;
  logic [IDX_W-1:0] link_wa, listed_wa, pinned_wa, link_wd;
  logic             listed_wd, pinned_wd;
  logic             tail_op;

  assign idx      = IDX_W'(idx8_r);
  assign rd_addr  = cmd.rd_head ? head_r : idx;
  assign clr_next = (clr_cnt_r == LAST_IDX) ? '0 : clr_cnt_r + IDX_W'(1);
  assign tail_op  = (func_r == bfla_pkg::FUNC_FREE_TAIL);

  // Write port selection
  always_comb begin
    link_we   = 1'b0;
    link_wa   = clr_cnt_r;
    link_wd   = clr_next;
    listed_we = 1'b0;
    listed_wa = clr_cnt_r;
    listed_wd = 1'b1;
    pinned_we = 1'b0;
    pinned_wa = clr_cnt_r;
    pinned_wd = 1'b0;
    priority if (cmd.clr_step) begin
      link_we   = 1'b1;
      listed_we = 1'b1;
      pinned_we = 1'b1;
    end else if (cmd.pop) begin
      listed_we = 1'b1;
      listed_wa = head_r;
      listed_wd = 1'b0;
    end else if (cmd.free_upd) begin
      listed_we = 1'b1;
      listed_wa = idx;
      if (tail_op) begin
        // the tail's link is dead while the list is empty
        link_we = !empty_r;
        link_wa = tail_r;
        link_wd = idx;
      end else begin
        link_we = 1'b1;
        link_wa = idx;
        link_wd = head_r;
      end
    end else if (cmd.pin_wr) begin
      pinned_we = 1'b1;
      pinned_wa = idx;
      pinned_wd = pin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we)   link_mem[link_wa]     <= link_wd;
    if (listed_we) listed_mem[listed_wa] <= listed_wd;
    if (pinned_we) pinned_mem[pinned_wa] <= pinned_wd;
    if (cmd.rd_en) begin
      link_rd_r   <= link_mem[rd_addr];
      listed_rd_r <= listed_mem[rd_addr];
      pinned_rd_r <= pinned_mem[rd_addr];
    end
  end

  // Latched request word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      idx8_r <= in_buffer_index;
      pin_r  <= in_pin_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      head_r    <= '0;
      tail_r    <= LAST_IDX;
      empty_r   <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_next;
      if (cmd.pop) begin
        if (head_r == tail_r) empty_r <= 1'b1;
        else head_r <= link_rd_r;
      end else if (cmd.free_upd) begin
        empty_r <= 1'b0;
        if (tail_op) begin
          tail_r <= idx;
          if (empty_r) head_r <= idx;
        end else begin
          head_r <= idx;
          if (empty_r) tail_r <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.res)
        bfla_pkg::RES_GRANT: begin
          granted_r <= 8'(head_r);
          status_r  <= bfla_pkg::STAT_DONE;
        end
        bfla_pkg::RES_EXHAUST: begin
          granted_r <= '0;
          status_r  <= bfla_pkg::STAT_EXHAUSTED;
        end
        bfla_pkg::RES_ECHO_LISTED: begin
          granted_r <= idx8_r;
          status_r  <= bfla_pkg::STAT_LISTED;
        end
        default: begin
          granted_r <= idx8_r;
          status_r  <= bfla_pkg::STAT_DONE;
        end
      endcase
    end
  end

  assign stat.clr_last = (clr_cnt_r == LAST_IDX);
  assign stat.empty    = empty_r;
  assign stat.in_range = (32'(idx8_r) < 32'(BUFFERS));
  assign stat.listed   = listed_rd_r;
  assign stat.pinned   = pinned_rd_r;
  assign stat.last_pop = (head_r == tail_r);

  assign out_valid         = out_valid_r;
  assign out_granted_index = granted_r;
  assign out_status        = status_r;

endmodule

// ===== rtl/buffer_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// buffer_free_list_allocator_unit
// Free list of buffer indices kept as a linked list with listed/pinned marks.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_func, in_buffer_index and in_pin_flag; the word is
//   taken at an edge where start is high and busy is low. Functions: get a
//   buffer, free at tail, free at head, set the pin mark.
//   Exactly one result per word: out_valid pulses for one cycle with
//   out_granted_index and out_status. The receiver cannot stall; a result
//   not taken in its cycle is gone.
//   Path from accept to result: pin PIN_WR; free FREE_CHK, FREE_EVAL
//   (FREE_CHK alone when the index is out of range); get GET_CHK, GET_EVAL,
//   both again per pinned entry skipped (one link memory read and one pop
//   per entry). An exhausted get on an empty list ends in GET_CHK.
//   busy is high from the accept edge until the result cycle, where it drops,
//   so the next word can be taken at the edge that ends the result cycle.
//   After reset a clearing pass walks all BUFFERS entries (256 by default)
//   of the link, listed and pinned memories, one entry a cycle; busy is high
//   throughout and every buffer ends up listed in order.
// ----------------------------------------------------------------------------
module buffer_free_list_allocator_unit #(
  parameter int BUFFERS = bfla_pkg::BUFFERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [7:0] in_buffer_index,
  input  logic       in_pin_flag,
  output logic       out_valid,
  output logic [7:0] out_granted_index,
  output logic [1:0] out_status
);

  bfla_pkg::cmd_t  cmd;
  bfla_pkg::stat_t stat;

  bfla_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  bfla_dp #(
    .BUFFERS (BUFFERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_func),
    .in_buffer_index   (in_buffer_index),
    .in_pin_flag       (in_pin_flag),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_status        (out_status)
  );

endmodule

// ===== rtl/bfla_chk.sv =====
// ----------------------------------------------------------------------------
// bfla_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfla_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_granted_index,
  input logic [1:0] out_status
);

  logic status_known;
  logic exhaust_out;

  assign status_known = (out_status == bfla_pkg::STAT_DONE) ||
                        (out_status == bfla_pkg::STAT_EXHAUSTED) ||
                        (out_status == bfla_pkg::STAT_LISTED);
  assign exhaust_out  = out_valid && (out_status == bfla_pkg::STAT_EXHAUSTED);

  // clearing pass holds the block busy right after reset
  `BFLA_ASSERT_ALWAYS(a_busy_after_rst, !rst_n |=> busy, "not busy after reset")
  `BFLA_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "idle after accepting a word")
  `BFLA_ASSERT(a_single_pulse, out_valid |=> !out_valid, "back-to-back results")
  `BFLA_ASSERT(a_status_code, out_valid |-> status_known, "undefined status code")
  `BFLA_ASSERT(a_exhaust_zero, exhaust_out |-> (out_granted_index == 8'd0), "exhausted get, index")

endmodule

bind buffer_free_list_allocator_unit bfla_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_granted_index (out_granted_index),
  .out_status        (out_status)
);

// ===== tb/bfla_checker.sv =====
// ----------------------------------------------------------------------------
// bfla_checker
// Watches the request and reply channels of the free-list allocator, keeps
// its own copy of the free list and compares every reply with the reply
// predicted for the matching request.
// ----------------------------------------------------------------------------
module bfla_checker #(
  parameter int BUFFERS = bfla_pkg::BUFFERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_func,
  input  logic [7:0] in_buffer_index,
  input  logic       in_pin_flag,
  input  logic       out_valid,
  input  logic [7:0] out_granted_index,
  input  logic [1:0] out_status,
  output int         mismatches,
  output int         replies_pending
);
  import bfla_pkg::*;

  typedef struct packed {
    logic [7:0] granted;
    logic [1:0] status;
  } reply_t;

  // Shadow of the allocator state
  logic [7:0] link_mem [BUFFERS];
  bit         on_list  [BUFFERS];
  bit         pinned   [BUFFERS];
  logic [7:0] head_ptr;
  logic [7:0] tail_ptr;
  bit         list_dry;

  reply_t replies_due [$];

  function automatic void clear_list();
    for (int i = 0; i < BUFFERS; i++) begin
      link_mem[i] = 8'((i + 1) % BUFFERS);
      on_list[i]  = 1'b1;
      pinned[i]   = 1'b0;
    end
    head_ptr = '0;
    tail_ptr = 8'(BUFFERS - 1);
    list_dry = 1'b0;
  endfunction

  // Apply one request to the shadow list and return the reply it causes.
  function automatic reply_t serve_request(logic [1:0] func, logic [7:0] idx, logic pin);
    reply_t     rep;
    logic [7:0] b;
    rep.granted = idx;
    rep.status  = STAT_DONE;
    if (func == FUNC_GET) begin
      rep.granted = '0;
      rep.status  = STAT_EXHAUSTED;
      // pop from the head, dropping pinned entries, until one is free to grant
      for (int n = 0; n < BUFFERS && !list_dry; n++) begin
        b = head_ptr;
        if (head_ptr == tail_ptr) list_dry = 1'b1;
        else head_ptr = link_mem[b];
        on_list[b] = 1'b0;
        if (!pinned[b]) begin
          rep.granted = b;
          rep.status  = STAT_DONE;
          break;
        end
      end
    end else if (int'(idx) < BUFFERS) begin
      if (func == FUNC_SET_PIN) begin
        pinned[idx] = pin;
      end else if (on_list[idx]) begin
        rep.status = STAT_LISTED;
      end else begin
        on_list[idx] = 1'b1;
        if (func == FUNC_FREE_TAIL) begin
          if (list_dry) head_ptr = idx;
          else link_mem[tail_ptr] = idx;
          tail_ptr = idx;
        end else begin
          if (list_dry) tail_ptr = idx;
          link_mem[idx] = head_ptr;
          head_ptr = idx;
        end
        list_dry = 1'b0;
      end
    end
    return rep;
  endfunction

  function automatic void flag_mismatch(string what, int want, int got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      clear_list();
      replies_due.delete();
    end else begin
      // retire the reply first so a reply in its own accept cycle is caught
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("reply with none pending, granted_index", -1,
                        int'(out_granted_index));
        end else begin
          want = replies_due.pop_front();
          if (out_granted_index !== want.granted)
            flag_mismatch("granted_index", int'(want.granted), int'(out_granted_index));
          if (out_status !== want.status)
            flag_mismatch("status", int'(want.status), int'(out_status));
        end
      end
      if (start && !busy)
        replies_due.push_back(serve_request(in_func, in_buffer_index, in_pin_flag));
    end
    replies_pending <= replies_due.size();
  end

endmodule

// ===== tb/tb_buffer_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_buffer_free_list_allocator_unit
// Drives get, free and pin requests into the free-list allocator: a directed
// opening, then random phases that drain the list dry and refill it, with
// bursty request timing. The checker beside the block scores every reply.
// ----------------------------------------------------------------------------
module tb_buffer_free_list_allocator_unit;
  import bfla_pkg::*;

  localparam int RANDOM_WORDS = 750;
  localparam int FIRST_DRAIN  = 320;
  localparam int PHASE_LEN    = 60;
  localparam int CYCLE_LIMIT  = 2000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_func = FUNC_GET;
  logic [7:0] in_buffer_index = '0;
  logic       in_pin_flag = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_granted_index;
  logic [1:0] out_status;

  int mismatches;
  int replies_pending;
  int cycles = 0;

  always #5 clk = ~clk;

  buffer_free_list_allocator_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_buffer_index   (in_buffer_index),
    .in_pin_flag       (in_pin_flag),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_status        (out_status)
  );

  bfla_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_buffer_index   (in_buffer_index),
    .in_pin_flag       (in_pin_flag),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_status        (out_status),
    .mismatches        (mismatches),
    .replies_pending   (replies_pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic issue_request(logic [1:0] func, logic [7:0] idx, logic pin);
    start           <= 1'b1;
    in_func         <= func;
    in_buffer_index <= idx;
    in_pin_flag     <= pin;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
  endtask

  // Random word; drain phases lean on get, fill phases on free.
  task automatic issue_random(bit drain);
    int         r;
    logic [1:0] func;
    logic [7:0] idx;
    r = $urandom_range(99);
    if (drain)
      func = (r < 80) ? FUNC_GET : (r < 86) ? FUNC_FREE_TAIL :
             (r < 92) ? FUNC_FREE_HEAD : FUNC_SET_PIN;
    else
      func = (r < 25) ? FUNC_GET : (r < 55) ? FUNC_FREE_TAIL :
             (r < 80) ? FUNC_FREE_HEAD : FUNC_SET_PIN;
    // a narrow window makes frees and pins collide with the list head often
    idx = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    issue_request(func, idx, $urandom_range(99) < 40);
  endtask

  initial begin
    int  sent;
    int  burst;
    bit  drain;
    bit  last_drain;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening
    issue_request(FUNC_GET, 8'hFF, 1'b1);        // grant buffer 0
    issue_request(FUNC_GET, 8'h00, 1'b0);        // grant buffer 1
    issue_request(FUNC_FREE_HEAD, 8'h00, 1'b0);
    issue_request(FUNC_FREE_TAIL, 8'h01, 1'b0);
    issue_request(FUNC_FREE_TAIL, 8'h00, 1'b0);  // already listed
    issue_request(FUNC_FREE_HEAD, 8'hFF, 1'b1);  // already listed
    hold_off(3);
    issue_request(FUNC_SET_PIN, 8'h00, 1'b1);
    issue_request(FUNC_SET_PIN, 8'h02, 1'b1);
    issue_request(FUNC_SET_PIN, 8'h03, 1'b1);
    issue_request(FUNC_GET, 8'hAA, 1'b0);        // skip pinned head entries
    issue_request(FUNC_FREE_TAIL, 8'h02, 1'b0);  // pinned but off the list
    issue_request(FUNC_SET_PIN, 8'h03, 1'b0);
    issue_request(FUNC_FREE_HEAD, 8'h03, 1'b0);
    issue_request(FUNC_GET, 8'h55, 1'b1);
    issue_request(FUNC_SET_PIN, 8'hFF, 1'b1);
    issue_request(FUNC_SET_PIN, 8'hFF, 1'b0);
    issue_request(FUNC_SET_PIN, 8'h00, 1'b0);
    issue_request(FUNC_GET, 8'h0F, 1'b0);
    drain_replies();

    // random phases: one long drain, then short fill and drain phases
    sent = 0;
    last_drain = 1'b1;
    while (sent < RANDOM_WORDS) begin
      drain = (sent < FIRST_DRAIN) ? 1'b1 : (((sent - FIRST_DRAIN) / PHASE_LEN) % 2 == 1);
      if (drain != last_drain && $urandom_range(1)) drain_replies();
      last_drain = drain;
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        issue_random(drain);
        sent++;
      end
      hold_off(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10));
    end

    drain_replies();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && replies_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== buffer_free_list_allocator_unit.f =====
+incdir+rtl
rtl/bfla_pkg.sv
rtl/bfla_ctrl.sv
rtl/bfla_dp.sv
rtl/buffer_free_list_allocator_unit.sv
rtl/bfla_chk.sv
tb/bfla_checker.sv
tb/tb_buffer_free_list_allocator_unit.sv
